// File: rtl/drum_voice_synth_core_defines.svh
// ----------------------------------------------------------------------------
// drum voice synth assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef DRUM_VOICE_SYNTH_CORE_DEFINES_SVH
`define DRUM_VOICE_SYNTH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DVS_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("drum voice synth assertion failed");
`define DVS_ASSERT(label, prop) `DVS_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define DVS_ASSERT_CLK(label, clk, rst_n, prop)
`define DVS_ASSERT(label, prop)
`endif
`endif

// File: rtl/dvs_pkg.sv
// ----------------------------------------------------------------------------
// dvs_pkg
// shared types, constants and the note decoder of the drum synth
// ----------------------------------------------------------------------------
`default_nettype none
package dvs_pkg;

  localparam int unsigned NUM_VOICES_DEF  = 8;
  localparam int unsigned SAMPLE_RATE_DEF = 48000;
  localparam int unsigned SINE_BITS_DEF   = 10;

  localparam logic [31:0] SEED_RESET = 32'd2463534242;
  localparam logic [23:0] GAIN_FLOOR = 24'd1678;

  // voice classes
  localparam logic [2:0] CLS_BASS  = 3'd0;
  localparam logic [2:0] CLS_SNARE = 3'd1;
  localparam logic [2:0] CLS_HAT   = 3'd2;
  localparam logic [2:0] CLS_N300  = 3'd3;
  localparam logic [2:0] CLS_N800  = 3'd4;
  localparam logic [2:0] CLS_RIDE  = 3'd5;
  localparam logic [2:0] CLS_N100  = 3'd6;

  localparam logic CMD_NOTE_ON = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // decay time per class in ms
  localparam logic [63:0] MS_OF [8] = '{64'd150, 64'd100, 64'd50, 64'd300,
                                        64'd800, 64'd400, 64'd100, 64'd100};

  typedef enum logic [2:0] {
    ST_IDLE, ST_NOTE, ST_READ, ST_MIX, ST_MULT, ST_ACC, ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic latch;     // capture the input request
    logic alloc;     // start a voice in the first free slot
    logic read;      // fetch slot state, noise and sine
    logic mix;       // form the weighted signal
    logic mult;      // gain and decay products
    logic acc;       // accumulate and write back
    logic next_slot; // advance the slot counter
    logic emit;      // load the output register
  } dvs_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic slot_active;
    logic last_slot;
    logic out_free;
  } dvs_status_t;

  function automatic logic [2:0] class_of(logic [6:0] note);
    logic [2:0] c;
    case (note) inside
      7'd35, 7'd36: c = CLS_BASS;
      7'd38, 7'd40: c = CLS_SNARE;
      7'd42:        c = CLS_HAT;
      7'd46:        c = CLS_N300;
      7'd49, 7'd57: c = CLS_N800;
      7'd51:        c = CLS_RIDE;
      default:      c = CLS_N100;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dvs_if.sv
// ----------------------------------------------------------------------------
// drum synth channel interfaces
// valid/ready channels for commands, samples and the seed register
// ----------------------------------------------------------------------------
`default_nettype none
interface dvs_cmd_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [6:0]         note;
  logic [6:0]         velocity;
  logic signed [15:0] mix_in;
  modport source (output valid, command, note, velocity, mix_in, input ready);
  modport sink   (input valid, command, note, velocity, mix_in, output ready);
endinterface

interface dvs_smp_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface dvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] noise_seed;
  modport source (output valid, noise_seed, input ready);
  modport sink   (input valid, noise_seed, output ready);
endinterface
`default_nettype wire

// File: rtl/dvs_ctrl.sv
// ----------------------------------------------------------------------------
// dvs_ctrl
// sequencer stepping each tick through the voice slots and each note_on through slot allocation
// ----------------------------------------------------------------------------
`default_nettype none
module dvs_ctrl
  import dvs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_command_i,
  output logic             in_ready_o,
  input  wire dvs_status_t status_i,
  output dvs_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = (in_command_i == CMD_TICK) ? ST_READ : ST_NOTE;
        end
      end
      ST_NOTE: begin
        cmd_o.alloc = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        if (status_i.slot_active) begin
          cmd_o.read = 1'b1;
          state_d = ST_MIX;
        end else if (status_i.last_slot) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.next_slot = 1'b1;
        end
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.last_slot) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/dvs_datapath.sv
// ----------------------------------------------------------------------------
// dvs_datapath
// voice state, noise generator, sine rom, multipliers and the mix accumulator
// ----------------------------------------------------------------------------
`default_nettype none
module dvs_datapath
  import dvs_pkg::*;
#(
  parameter int unsigned NumVoices  = NUM_VOICES_DEF,
  parameter int unsigned SampleRate = SAMPLE_RATE_DEF,
  parameter int unsigned SineBits   = SINE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dvs_cmd_t           cmd_i,
  output dvs_status_t             status_o,
  input  wire logic               command_i,
  input  wire logic [6:0]         note_i,
  input  wire logic [6:0]         velocity_i,
  input  wire logic signed [15:0] mix_in_i,
  input  wire logic               seed_we_i,
  input  wire logic [31:0]        seed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [19:0]      sample_out_o
);

  localparam int unsigned SlotW    = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam int unsigned AccW     = 20 + $clog2(NumVoices + 1);
  localparam int unsigned TableLen = 1 << SineBits;
  localparam logic [31:0] Step60  = 32'(((64'd60 << 32) + 64'(SampleRate / 2)) / SampleRate);
  localparam logic [31:0] Step200 = 32'(((64'd200 << 32) + 64'(SampleRate / 2)) / SampleRate);
  localparam logic [31:0] Step600 = 32'(((64'd600 << 32) + 64'(SampleRate / 2)) / SampleRate);
  localparam logic signed [15:0] W07 = 16'sd22938;
  localparam logic signed [15:0] W03 = 16'sd9830;
  localparam logic signed [15:0] W06 = 16'sd19661;
  localparam logic signed [15:0] W04 = 16'sd13107;
  localparam logic signed [AccW-1:0] OutMax = AccW'(524287);
  localparam logic signed [AccW-1:0] OutMin = -AccW'(524288);
  localparam logic [63:0] Scale48 = 64'd1 << 48;
  localparam logic [63:0] Quarter = 64'd1 << (SineBits - 2);

  // constant tables
  logic [23:0]        coef_tab [8];
  logic [15:0]        sine_rom [TableLen];
  logic [23:0]        gain_rom [128];

  for (genvar c = 0; c < 8; c++) begin : g_coef
    localparam logic [63:0] D  = MS_OF[c] * 64'(SampleRate);
    localparam logic [63:0] T1 = (Scale48 * 64'd1000) / D;
    localparam logic [63:0] T2 = (T1 * 64'd1000) / D / 64'd2;
    localparam logic [63:0] T3 = (T2 * 64'd1000) / D / 64'd3;
    localparam logic [63:0] Cf = Scale48 - T1 + T2 - T3;
    assign coef_tab[c] = 24'((Cf + 64'd8388608) >> 24);
  end
  // taylor sine in Q2.30 over the folded quarter wave
  for (genvar k = 0; k < TableLen; k++) begin : g_sine
    localparam logic [63:0] Q   = 64'(k) >> (SineBits - 2);
    localparam logic [63:0] R   = 64'(k) & (Quarter - 64'd1);
    localparam logic [63:0] A   = Q[0] ? Quarter - R : R;
    localparam logic [63:0] Th  = (A * 64'd6746518852) >> SineBits;
    localparam logic [63:0] X2  = (Th * Th) >> 30;
    localparam logic [63:0] T1  = ((Th * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] Sum = Th - T1 + T2 - T3 + T4 - T5 + T6 - T7;
    localparam logic [63:0] V0  = (Sum + 64'd16384) >> 15;
    localparam logic [63:0] V   = (V0 > 64'd32767) ? 64'd32767 : V0;
    assign sine_rom[k] = (Q >= 64'd2) ? 16'(-V) : V[15:0];
  end
  for (genvar v = 0; v < 128; v++) begin : g_gain
    localparam logic [63:0] Gv = (64'(v) * 64'd7 * 64'd16777216 + 64'd635) / 64'd1270;
    assign gain_rom[v] = Gv[23:0];
  end

  // voice state
  logic [NumVoices-1:0] active_q;
  logic [2:0]           cls_mem   [NumVoices];
  logic [23:0]          gain_mem  [NumVoices];
  logic [31:0]          phase_mem [NumVoices];
  logic signed [15:0]   prev_mem  [NumVoices];

  logic [SlotW-1:0]     slot_q;
  logic                 is_tick_q;
  logic [6:0]           note_q, vel_q;
  logic [31:0]          noise_gen_q;
  logic [2:0]           cls_q;
  logic [23:0]          g_q, gd_q;
  logic [31:0]          ph_q;
  logic signed [15:0]   n_q, sine_q;
  logic signed [31:0]   x_q;
  logic                 wide_q;
  logic signed [56:0]   prod_q;
  logic signed [AccW-1:0] acc_q;
  logic                 out_valid_q;
  logic signed [19:0]   out_q;

  // xorshift32 step
  logic [31:0] r1, r2, r3;
  assign r1 = noise_gen_q ^ (noise_gen_q << 13);
  assign r2 = r1 ^ (r1 >> 17);
  assign r3 = r2 ^ (r2 << 5);

  logic uses_noise;
  assign uses_noise = (cls_mem[slot_q] != CLS_BASS) && (cls_mem[slot_q] != 3'd7);

  // first free slot
  logic             free_found;
  logic [SlotW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumVoices - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  logic [47:0]          decay_prod;
  logic signed [56:0]   voice_s;
  logic signed [AccW-1:0] acc_sum;
  assign decay_prod = g_q * coef_tab[cls_q];
  assign voice_s    = wide_q ? (prod_q >>> 39) : (prod_q >>> 24);
  assign acc_sum    = acc_q + AccW'(voice_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      noise_gen_q <= SEED_RESET;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      is_tick_q   <= 1'b0;
    end else begin
      if (seed_we_i) noise_gen_q <= seed_i;
      if (cmd_i.latch) begin
        is_tick_q <= command_i;
        slot_q    <= '0;
      end
      if (cmd_i.next_slot) slot_q <= slot_q + SlotW'(1);
      if (cmd_i.alloc && free_found) active_q[free_idx] <= 1'b1;
      if (cmd_i.read && uses_noise) noise_gen_q <= r3;
      if (cmd_i.acc) active_q[slot_q] <= (gd_q >= GAIN_FLOOR);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      note_q <= note_i;
      vel_q  <= velocity_i;
      acc_q  <= AccW'(mix_in_i);
    end
    if (cmd_i.alloc && free_found) begin
      cls_mem[free_idx]   <= class_of(note_q);
      gain_mem[free_idx]  <= gain_rom[vel_q];
      phase_mem[free_idx] <= '0;
      prev_mem[free_idx]  <= '0;
    end
    if (cmd_i.read) begin
      cls_q  <= cls_mem[slot_q];
      g_q    <= gain_mem[slot_q];
      ph_q   <= phase_mem[slot_q];
      sine_q <= sine_rom[phase_mem[slot_q][31 -: SineBits]];
      n_q    <= r3[31:16];
    end
    if (cmd_i.mix) begin
      wide_q <= (cls_q == CLS_SNARE) || (cls_q == CLS_RIDE);
      case (cls_q)
        CLS_BASS:  x_q <= 32'(sine_q);
        CLS_SNARE: x_q <= 32'(W07 * n_q) + 32'(W03 * sine_q);
        CLS_HAT:   x_q <= 32'(n_q) - 32'(prev_mem[slot_q]);
        CLS_RIDE:  x_q <= 32'(W06 * n_q) + 32'(W04 * sine_q);
        CLS_N300, CLS_N800, CLS_N100: x_q <= 32'(n_q);
        default:   x_q <= '0;
      endcase
    end
    if (cmd_i.mult) begin
      prod_q <= $signed({1'b0, g_q}) * x_q;
      gd_q   <= decay_prod[47:24];
    end
    if (cmd_i.acc) begin
      acc_q <= acc_sum;
      gain_mem[slot_q] <= gd_q;
      case (cls_q)
        CLS_BASS:  phase_mem[slot_q] <= ph_q + Step60;
        CLS_SNARE: phase_mem[slot_q] <= ph_q + Step200;
        CLS_RIDE:  phase_mem[slot_q] <= ph_q + Step600;
        default:   phase_mem[slot_q] <= ph_q;
      endcase
      if (cls_q == CLS_HAT) prev_mem[slot_q] <= n_q;
    end
    if (cmd_i.emit) begin
      if (acc_q > OutMax) out_q <= 20'sd524287;
      else if (acc_q < OutMin) out_q <= -20'sd524288;
      else out_q <= acc_q[19:0];
    end
  end

  assign status_o.is_tick     = is_tick_q;
  assign status_o.slot_active = active_q[slot_q];
  assign status_o.last_slot   = (32'(slot_q) == NumVoices - 1);
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign sample_out_o         = out_q;

endmodule
`default_nettype wire

// File: rtl/drum_voice_synth_core.sv
// ----------------------------------------------------------------------------
// drum_voice_synth_core
// note_on starts a drum voice, tick mixes every active voice onto mix_in
// ----------------------------------------------------------------------------
//  channel  dir  payload                              request moves on
//  cmd_i    in   command, note, velocity, mix_in      valid & ready
//  smp_o    out  sample_out (Q5.15, saturated)        valid & ready
//  cfg_i    in   noise_seed                           valid & ready (always ready)
//
//  note_on latches the request, then allocates a slot; tick walks the slots, an idle
//  slot just advancing, an active one going through read, mix, multiply, accumulate
//  one request at a time; the sample waits in an output register while the
//  next request is taken, and a tick stalls only when that register is full
//  reset clears the active flags and loads the default seed, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
`include "drum_voice_synth_core_defines.svh"
module drum_voice_synth_core
  import dvs_pkg::*;
#(
  parameter int unsigned NumVoices  = NUM_VOICES_DEF,
  parameter int unsigned SampleRate = SAMPLE_RATE_DEF,
  parameter int unsigned SineBits   = SINE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dvs_cmd_if.sink   cmd_i,
  dvs_smp_if.source smp_o,
  dvs_cfg_if.sink   cfg_i
);

  dvs_cmd_t    cmd;
  dvs_status_t status;

  // seed register always takes writes
  assign cfg_i.ready = 1'b1;

  dvs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_i.valid),
    .in_command_i (cmd_i.command),
    .in_ready_o   (cmd_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // slot walk, noise, sine lookup and mixing
  dvs_datapath #(
    .NumVoices  (NumVoices),
    .SampleRate (SampleRate),
    .SineBits   (SineBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .command_i    (cmd_i.command),
    .note_i       (cmd_i.note),
    .velocity_i   (cmd_i.velocity),
    .mix_in_i     (cmd_i.mix_in),
    .seed_we_i    (cfg_i.valid),
    .seed_i       (cfg_i.noise_seed),
    .out_valid_o  (smp_o.valid),
    .out_ready_i  (smp_o.ready),
    .sample_out_o (smp_o.sample_out)
  );

  // a note_on never yields a sample on the next edge
  `DVS_ASSERT(a_note_no_sample,
    (cmd_i.valid && cmd_i.ready && cmd_i.command == CMD_NOTE_ON) |=> !$rose(smp_o.valid))
  // a tick needs at least the slot walk before its sample appears
  `DVS_ASSERT(a_tick_not_immediate,
    (cmd_i.valid && cmd_i.ready && cmd_i.command == CMD_TICK) |=> !$rose(smp_o.valid))
  // the output register is only loaded by a tick
  `DVS_ASSERT(a_emit_tick, cmd.emit |-> status.is_tick)

endmodule
`default_nettype wire

// File: test/tb_drum_voice_synth_core.sv
// ----------------------------------------------------------------------------
// tb_drum_voice_synth_core
// drives note_on and tick requests with random gaps and output stalls, keeps
// its own bit-exact drum voice model and checks every mixed sample in order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_drum_voice_synth_core;
  import dvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICES = 8;
  localparam int TAB_BITS = 10;
  localparam int TAB_LEN = 1 << TAB_BITS;
  localparam int RATE = 48000;
  localparam int N_RANDOM = 1600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  dvs_cmd_if cmd_bus ();
  dvs_smp_if smp_bus ();
  dvs_cfg_if cfg_bus ();

  drum_voice_synth_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .smp_o (smp_bus),
    .cfg_i (cfg_bus)
  );

  // model of the synth: generator, voice slots and constant tables
  logic [31:0]        lfsr_state;
  logic               slot_on     [VOICES];
  logic [2:0]         slot_cls    [VOICES];
  logic [31:0]        slot_gain   [VOICES];
  logic [31:0]        slot_phase  [VOICES];
  logic signed [31:0] slot_prev   [VOICES];
  logic signed [31:0] wave        [TAB_LEN];
  logic [31:0]        fade        [8];
  logic signed [19:0] sample_fifo [$];
  int                 err_count = 0;
  logic               out_quiet = 1'b0;

  // taylor sine in Q2.30, angle given in Q2.30 radians
  function automatic longint unsigned taylor_sin(longint unsigned ang);
    longint unsigned sq, trm, acc;
    sq = (ang * ang) >> 30;
    trm = ang;
    acc = ang;
    for (int n = 1; n <= 7; n++) begin
      trm = ((trm * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - trm;
      else acc = acc + trm;
    end
    return acc;
  endfunction

  function automatic logic [31:0] fade_coeff(longint unsigned ms);
    longint unsigned den, one, t1, t2, t3, c;
    den = ms * RATE;
    one = 64'd1 << 48;
    t1 = (one * 1000) / den;
    t2 = (t1 * 1000) / den / 2;
    t3 = (t2 * 1000) / den / 3;
    c = one - t1 + t2 - t3;
    return 32'((c + (64'd1 << 23)) >> 24);
  endfunction

  function automatic logic [31:0] step_of(longint unsigned hz);
    return 32'(((hz << 32) + RATE / 2) / RATE);
  endfunction

  function automatic logic [2:0] drum_class(logic [6:0] nt);
    case (nt)
      7'd35, 7'd36: return CLS_BASS;
      7'd38, 7'd40: return CLS_SNARE;
      7'd42:        return CLS_HAT;
      7'd46:        return CLS_N300;
      7'd49, 7'd57: return CLS_N800;
      7'd51:        return CLS_RIDE;
      default:      return CLS_N100;
    endcase
  endfunction

  function automatic longint noise_step();
    logic [31:0] r;
    r = lfsr_state;
    r ^= r << 13;
    r ^= r >> 17;
    r ^= r << 5;
    lfsr_state = r;
    return longint'($signed(r[31:16]));
  endfunction

  function automatic longint tone_at(logic [31:0] ph);
    return longint'(wave[ph[31 -: TAB_BITS]]);
  endfunction

  // floor(g * x / 2^sh)
  function automatic longint gain_mul(logic [31:0] g, longint x, int sh);
    return (longint'(g) * x) >>> sh;
  endfunction

  function automatic longint voice_sample(int i);
    longint s, n, t;
    s = 0;
    case (slot_cls[i])
      CLS_BASS: begin
        s = gain_mul(slot_gain[i], tone_at(slot_phase[i]), 24);
        slot_phase[i] += step_of(60);
      end
      CLS_SNARE: begin
        n = noise_step();
        t = tone_at(slot_phase[i]);
        s = gain_mul(slot_gain[i], 22938 * n + 9830 * t, 39);
        slot_phase[i] += step_of(200);
      end
      CLS_HAT: begin
        n = noise_step();
        s = gain_mul(slot_gain[i], n - longint'(slot_prev[i]), 24);
        slot_prev[i] = 32'(n);
      end
      CLS_N300, CLS_N800, CLS_N100: s = gain_mul(slot_gain[i], noise_step(), 24);
      CLS_RIDE: begin
        n = noise_step();
        t = tone_at(slot_phase[i]);
        s = gain_mul(slot_gain[i], 19661 * n + 13107 * t, 39);
        slot_phase[i] += step_of(600);
      end
      default: s = 0;
    endcase
    slot_gain[i] = 32'((64'(slot_gain[i]) * 64'(fade[slot_cls[i]])) >> 24);
    if (slot_gain[i] < 32'(GAIN_FLOOR)) slot_on[i] = 1'b0;
    return s;
  endfunction

  // applies one accepted request, returns 1 with the mixed sample for a tick
  function automatic bit synth_step(logic cmd, logic [6:0] nt, logic [6:0] vel,
                                    logic signed [15:0] mix, output logic signed [19:0] smp);
    longint acc;
    smp = '0;
    if (cmd == CMD_NOTE_ON) begin
      for (int i = 0; i < VOICES; i++) begin
        if (!slot_on[i]) begin
          slot_on[i] = 1'b1;
          slot_cls[i] = drum_class(nt);
          slot_gain[i] = 32'((64'(vel) * 7 * 16777216 + 635) / 1270);
          slot_phase[i] = '0;
          slot_prev[i] = '0;
          break;
        end
      end
      return 1'b0;
    end
    acc = longint'(mix);
    for (int i = 0; i < VOICES; i++)
      if (slot_on[i]) acc += voice_sample(i);
    if (acc > 524287) acc = 524287;
    if (acc < -524288) acc = -524288;
    smp = 20'(acc);
    return 1'b1;
  endfunction

  initial begin
    int quarter, q, r, a;
    longint unsigned th, v;
    quarter = TAB_LEN / 4;
    for (int k = 0; k < TAB_LEN; k++) begin
      q = k / quarter;
      r = k % quarter;
      a = (q % 2 == 1) ? quarter - r : r;
      th = (longint'(a) * 64'd6746518852) / TAB_LEN;
      v = (taylor_sin(th) + (1 << 14)) >> 15;
      if (v > 32767) v = 32767;
      wave[k] = (q >= 2) ? -32'(v) : 32'(v);
    end
    fade = '{fade_coeff(150), fade_coeff(100), fade_coeff(50), fade_coeff(300),
             fade_coeff(800), fade_coeff(400), fade_coeff(100), fade_coeff(100)};
    lfsr_state = SEED_RESET;
    for (int i = 0; i < VOICES; i++) slot_on[i] = 1'b0;
  end

  // sample side: random stalls except during the quiet stretch
  always @(negedge clk_i) begin
    if (!rst_ni) smp_bus.ready <= 1'b0;
    else smp_bus.ready <= out_quiet || ($urandom_range(99) >= 28);
  end

  // compare each sample with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && smp_bus.valid && smp_bus.ready) begin
      if (sample_fifo.size() == 0) begin
        $error("sample_out: none expected, got %0d", smp_bus.sample_out);
        err_count++;
      end else begin
        if (smp_bus.sample_out !== sample_fifo[0]) begin
          $error("sample_out: expected %0d, got %0d", sample_fifo[0], smp_bus.sample_out);
          err_count++;
        end
        void'(sample_fifo.pop_front());
      end
    end
  end

  // one request on the command channel, with a random gap first; valid stays
  // up until the next gap or the next request replaces it
  task automatic send_request(logic cmd, logic [6:0] nt, logic [6:0] vel,
                              logic signed [15:0] mix, bit typed, logic signed [19:0] want);
    logic signed [19:0] smp;
    while (!out_quiet && $urandom_range(99) < 28) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= cmd;
    cmd_bus.note <= nt;
    cmd_bus.velocity <= vel;
    cmd_bus.mix_in <= mix;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (synth_step(cmd, nt, vel, mix, smp)) sample_fifo.push_back(typed ? want : smp);
    @(negedge clk_i);
  endtask

  // seed write, only once every expected sample is out and the block is idle
  task automatic load_seed(logic [31:0] seed);
    cmd_bus.valid <= 1'b0;
    wait (sample_fifo.size() == 0);
    repeat (40) @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.noise_seed <= seed;
    do @(posedge clk_i); while (!cfg_bus.ready);
    lfsr_state = seed;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  typedef struct {
    logic               cmd;
    logic [6:0]         nt;
    logic [6:0]         vel;
    logic signed [15:0] mix;
    bit                 typed;
    logic signed [19:0] want;
  } drum_row_t;

  // silence passes mix_in straight through; then fill all slots, one dropped
  drum_row_t drum_rows[] = '{
    '{CMD_TICK,    7'd0,   7'd0,   16'sh7FFF, 1'b1, 20'sd32767},
    '{CMD_TICK,    7'd127, 7'd127, 16'sh8000, 1'b1, -20'sd32768},
    '{CMD_TICK,    7'd0,   7'd0,   16'sh0000, 1'b1, 20'sd0},
    '{CMD_NOTE_ON, 7'd36,  7'd0,   16'sh7FFF, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd0,   7'd0,   16'sh0001, 1'b1, 20'sd1},
    '{CMD_NOTE_ON, 7'd35,  7'd127, 16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd38,  7'd100, 16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd40,  7'd1,   16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd42,  7'd127, 16'sh0000, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd0,   7'd0,   16'sh7FFF, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd46,  7'd64,  16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd49,  7'd127, 16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd51,  7'd127, 16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd0,   7'd85,  16'sh0000, 1'b0, 20'sd0},
    '{CMD_NOTE_ON, 7'd57,  7'd127, 16'sh0000, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd127, 7'd127, 16'sh8000, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd0,   7'd0,   16'sh7FFF, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd0,   7'd0,   16'sh5555, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd0,   7'd0,   16'shAAAA, 1'b0, 20'sd0},
    '{CMD_TICK,    7'd0,   7'd0,   16'sh0000, 1'b0, 20'sd0}
  };

  logic [6:0] drum_notes[] = '{7'd35, 7'd36, 7'd38, 7'd40, 7'd42, 7'd46,
                               7'd49, 7'd57, 7'd51, 7'd0, 7'd127, 7'd85};

  initial begin
    logic       cmd;
    logic [6:0] nt, vel;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_TICK;
    cmd_bus.note = '0;
    cmd_bus.velocity = '0;
    cmd_bus.mix_in = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.noise_seed = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part runs on the reset seed
    foreach (drum_rows[i])
      send_request(drum_rows[i].cmd, drum_rows[i].nt, drum_rows[i].vel, drum_rows[i].mix,
                   drum_rows[i].typed, drum_rows[i].want);

    // random part in four seed phases, the second one without any stalls
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_seed(32'hFFFF_FFFF);
        1: load_seed(32'h0000_0000);
        2: load_seed(32'h0000_0001);
        default: load_seed($urandom());
      endcase
      out_quiet = (ph == 1);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        cmd = ($urandom_range(99) < 75) ? CMD_TICK : CMD_NOTE_ON;
        nt = ($urandom_range(3) == 0) ? 7'($urandom()) :
             drum_notes[$urandom_range(drum_notes.size() - 1)];
        // zero velocity frees its slot after one tick, keeping note_on useful
        vel = ($urandom_range(99) < 45) ? 7'd0 : 7'($urandom());
        send_request(cmd, nt, vel, 16'($urandom()), 1'b0, 20'sd0);
      end
      out_quiet = 1'b0;
    end

    cmd_bus.valid <= 1'b0;
    wait (sample_fifo.size() == 0);
    repeat (60) @(posedge clk_i);
    if (err_count == 0 && sample_fifo.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
